// ===== rtl/rotating_hue_wheel_pattern_macros.svh =====
// Assertion macros shared by the hue wheel RTL.
// No dependencies; files that assert take this header by `include.
`ifndef ROTATING_HUE_WHEEL_PATTERN_MACROS_SVH
`define ROTATING_HUE_WHEEL_PATTERN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RHW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RHW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rhw_pkg.sv =====
// Types, constants and CORDIC tables of the rotating hue wheel generator.
// No dependencies; used by both cell types, the top level and the testbench.
`default_nettype none

package rhw_pkg;

  // Pixel grid default and register reset values
  localparam int unsigned IMAGE_SIDE_DEF = 256;
  localparam logic [15:0] RADIUS_SQ_RST  = 16'd10000;
  localparam logic [15:0] PHASE_STEP_RST = 16'd1043;

  // Register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_RADIUS_SQ  = 1'b0,
    REG_PHASE_STEP = 1'b1
  } reg_idx_e;

  // Angles: 16-bit fraction of a full turn, wrapping
  typedef logic [15:0] angle_t;
  localparam angle_t HALF_TURN       = 16'd32768;
  localparam angle_t TURN_THIRD      = 16'd21845;
  localparam angle_t TURN_TWO_THIRDS = 16'd43691;

  localparam int unsigned CORDIC_STAGES = 15;
  localparam angle_t STAGE_ANGLE [CORDIC_STAGES] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
  };

  // Color channels and their hue offsets (red, green, blue)
  localparam int unsigned NUM_CH = 3;
  localparam angle_t CH_OFFSET [NUM_CH] = '{16'd0, TURN_THIRD, TURN_TWO_THIRDS};

  // Sine CORDIC datapath: Q16 x/y with headroom, folded residual angle
  localparam int unsigned SIN_W   = 19;
  localparam int unsigned SIN_S_W = 17;
  typedef logic signed [SIN_W-1:0]   sin_xy_t;
  typedef logic signed [SIN_S_W-1:0] sin_ang_t;
  localparam sin_xy_t  CORDIC_GAIN_Q16 = 19'sd39797;
  localparam sin_ang_t QUARTER_TURN_S  = 17'sd16384;
  localparam sin_ang_t HALF_TURN_S     = 17'sd32768;

  typedef struct packed {
    sin_xy_t  x;
    sin_xy_t  y;
    sin_ang_t s;
  } sin_lane_t;

  // Per-pixel tags that ride along the arctangent chain
  typedef struct packed {
    angle_t phase;
    logic   white;
    logic   zero;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/rhw_pixel_if.sv =====
// Pixel coordinate channel: valid/ready plus row, column and frame start.
// No dependencies.
`default_nettype none

interface rhw_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] row;
  logic [7:0] col;
  logic       frame_start;

  modport source (output valid, row, col, frame_start, input ready);
  modport sink   (input valid, row, col, frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/rhw_color_if.sv =====
// Color channel: valid/ready plus red, green and blue.
// No dependencies.
`default_nettype none

interface rhw_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/rhw_atan_cell.sv =====
// One vectoring-mode CORDIC cell of the arctangent chain, with its own register.
// Depends on rhw_pkg.
`default_nettype none

module rhw_atan_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  up_valid_i,
  output logic                       up_ready_o,
  input  wire logic signed [AW-1:0]  x_i,
  input  wire logic signed [AW-1:0]  y_i,
  input  wire rhw_pkg::angle_t       z_i,
  input  wire rhw_pkg::side_t        side_i,
  output logic                       dn_valid_o,
  input  wire logic                  dn_ready_i,
  output logic signed [AW-1:0]       x_o,
  output logic signed [AW-1:0]       y_o,
  output rhw_pkg::angle_t            z_o,
  output rhw_pkg::side_t             side_o
);
  import rhw_pkg::*;

  logic                valid_q;
  logic signed [AW-1:0] x_d, y_d, x_q, y_q;
  angle_t              z_d, z_q;
  side_t               side_q;

  // Rotate toward the x axis; direction from the sign of y
  always_comb begin
    if (!y_i[AW-1]) begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + STAGE_ANGLE[IDX];
    end else begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - STAGE_ANGLE[IDX];
    end
  end

  // Pipeline handshake: load when empty or when the neighbor takes ours
  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign z_o        = z_q;
  assign side_o     = side_q;

endmodule

`default_nettype wire

// ===== rtl/rhw_sin_cell.sv =====
// One rotation-mode CORDIC cell of the sine chain, all three color lanes.
// Depends on rhw_pkg.
`default_nettype none

module rhw_sin_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    up_valid_i,
  output logic                                         up_ready_o,
  input  wire rhw_pkg::sin_lane_t [rhw_pkg::NUM_CH-1:0] lane_i,
  input  wire logic                                    white_i,
  output logic                                         dn_valid_o,
  input  wire logic                                    dn_ready_i,
  output rhw_pkg::sin_lane_t [rhw_pkg::NUM_CH-1:0]     lane_o,
  output logic                                         white_o
);
  import rhw_pkg::*;

  localparam sin_ang_t STEP = sin_ang_t'({1'b0, STAGE_ANGLE[IDX]});

  logic                        valid_q;
  sin_lane_t [NUM_CH-1:0]      lane_d, lane_q;
  logic                        white_q;

  // Rotate each lane by the stage angle toward a zero residual
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (!lane_i[k].s[SIN_S_W-1]) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> IDX);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> IDX);
        lane_d[k].s = lane_i[k].s - STEP;
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> IDX);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> IDX);
        lane_d[k].s = lane_i[k].s + STEP;
      end
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      lane_q  <= lane_d;
      white_q <= white_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign lane_o     = lane_q;
  assign white_o    = white_q;

endmodule

`default_nettype wire

// ===== rtl/rotating_hue_wheel_pattern.sv =====
// Rotating hue wheel test pattern: pixel coordinate in, RGB color out.
// Depends on rhw_pkg, rhw_pixel_if, rhw_color_if, rhw_atan_cell, rhw_sin_cell
// and rotating_hue_wheel_pattern_macros.svh.
//
//  Channel   Dir  Handshake             Payload
//  pix_i     in   valid/ready           row[7:0], col[7:0], frame_start
//  rgb_o     out  valid/ready           red[7:0], green[7:0], blue[7:0]
//  cfg       in   cfg_we_i (no ready)   cfg_idx_i, cfg_wdata_i[15:0]
//
// One pixel per cycle unless the output stalls; stages: coordinate stage,
// square stage, 15 arctangent CORDIC cells, angle stage, 15 sine CORDIC
// cells (three lanes each), output register. The two chains set the latency.
// Reset empties the pipeline, clears the phase and loads register defaults.
// Every cell holds while its successor is full and stalled; empty cells keep
// filling, so pixels are taken while a finished color waits at the output.
`default_nettype none
`include "rotating_hue_wheel_pattern_macros.svh"

module rotating_hue_wheel_pattern #(
  parameter int unsigned IMAGE_SIDE = rhw_pkg::IMAGE_SIDE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rhw_pixel_if.sink        pix_i,
  rhw_color_if.source      rgb_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import rhw_pkg::*;

  // Centered coordinate width, CORDIC width, square and distance widths
  localparam int unsigned CW  = ($clog2(IMAGE_SIDE) + 1 > 10) ? $clog2(IMAGE_SIDE) + 1 : 10;
  localparam int unsigned AW  = CW + 10;
  localparam int unsigned SQW = 2 * CW;
  localparam int unsigned DW  = SQW + 1;
  localparam int unsigned N   = CORDIC_STAGES;

  // ---------------------------------------------------------------- config
  logic [15:0] radius_sq_q, phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq_q  <= RADIUS_SQ_RST;
      phase_step_q <= PHASE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RADIUS_SQ:  radius_sq_q  <= cfg_wdata_i;
        REG_PHASE_STEP: phase_step_q <= cfg_wdata_i;
      endcase
    end
  end

  // ------------------------------------------------------- coordinate stage
  logic                 pix_acc;
  angle_t               wheel_phase_d, wheel_phase_q;
  logic signed [CW-1:0] pix_y, pix_x;
  logic                 f_valid_q, f_ready;
  logic signed [CW-1:0] f_y_q, f_x_q;
  logic                 f_zero_q;
  angle_t               f_phase_q;

  assign pix_acc = pix_i.valid && pix_i.ready;

  assign pix_y = $signed({{(CW-9){1'b0}}, pix_i.row, 1'b0}) - $signed(CW'(IMAGE_SIDE - 1));
  assign pix_x = $signed({{(CW-9){1'b0}}, pix_i.col, 1'b0}) - $signed(CW'(IMAGE_SIDE - 1));

  // Phase advances at the transaction that opens a frame
  assign wheel_phase_d = (pix_acc && pix_i.frame_start) ? wheel_phase_q + phase_step_q
                                                        : wheel_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_phase_q <= '0;
      f_valid_q     <= 1'b0;
    end else begin
      wheel_phase_q <= wheel_phase_d;
      if (pix_i.ready) begin
        f_valid_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      f_y_q     <= pix_y;
      f_x_q     <= pix_x;
      f_zero_q  <= (pix_y == '0) && (pix_x == '0);
      f_phase_q <= wheel_phase_d;
    end
  end

  assign pix_i.ready = !f_valid_q || f_ready;

  // ----------------------------------------------------------- square stage
  logic signed [SQW-1:0] sq_y, sq_x;
  logic                  q_valid_q, q_ready;
  logic [SQW-1:0]        q_yy_q, q_xx_q;
  logic signed [CW-1:0]  q_y_q, q_x_q;
  logic                  q_zero_q;
  angle_t                q_phase_q;

  assign sq_y    = f_y_q * f_y_q;
  assign sq_x    = f_x_q * f_x_q;
  assign f_ready = !q_valid_q || q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (f_ready) begin
      q_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_valid_q && f_ready) begin
      q_yy_q    <= sq_y;
      q_xx_q    <= sq_x;
      q_y_q     <= f_y_q;
      q_x_q     <= f_x_q;
      q_zero_q  <= f_zero_q;
      q_phase_q <= f_phase_q;
    end
  end

  // ------------------------------------------------------ arctangent chain
  logic                 at_valid [N+1];
  logic                 at_ready [N+1];
  logic signed [AW-1:0] at_x     [N+1];
  logic signed [AW-1:0] at_y     [N+1];
  angle_t               at_z     [N+1];
  side_t                at_side  [N+1];

  logic [DW-1:0]        dist_sq;
  logic signed [AW-1:0] xs, ys;

  // Disc test, 2^8 prescale, left half plane turned by a half turn
  assign dist_sq = {1'b0, q_yy_q} + {1'b0, q_xx_q};
  assign xs      = {{2{q_x_q[CW-1]}}, q_x_q, 8'd0};
  assign ys      = {{2{q_y_q[CW-1]}}, q_y_q, 8'd0};

  assign at_valid[0]      = q_valid_q;
  assign q_ready          = at_ready[0];
  assign at_x[0]          = xs[AW-1] ? -xs : xs;
  assign at_y[0]          = xs[AW-1] ? -ys : ys;
  assign at_z[0]          = xs[AW-1] ? HALF_TURN : '0;
  assign at_side[0].phase = q_phase_q;
  assign at_side[0].white = dist_sq > DW'({radius_sq_q, 2'b00});
  assign at_side[0].zero  = q_zero_q;

  for (genvar i = 0; i < N; i++) begin : g_atan
    rhw_atan_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (at_valid[i]),
      .up_ready_o (at_ready[i]),
      .x_i        (at_x[i]),
      .y_i        (at_y[i]),
      .z_i        (at_z[i]),
      .side_i     (at_side[i]),
      .dn_valid_o (at_valid[i+1]),
      .dn_ready_i (at_ready[i+1]),
      .x_o        (at_x[i+1]),
      .y_o        (at_y[i+1]),
      .z_o        (at_z[i+1]),
      .side_o     (at_side[i+1])
    );
  end

  // ------------------------------------------------------------ angle stage
  logic   a_valid_q, a_ready;
  angle_t a_ang_d, a_ang_q;
  logic   a_white_q;

  // Center pixel has no direction: its angle is taken as zero
  assign a_ang_d      = (at_side[N].zero ? '0 : at_z[N]) + at_side[N].phase;
  assign at_ready[N]  = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (at_ready[N]) begin
      a_valid_q <= at_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (at_valid[N] && at_ready[N]) begin
      a_ang_q   <= a_ang_d;
      a_white_q <= at_side[N].white;
    end
  end

  // ------------------------------------------------------------ sine chain
  logic                   sn_valid [N+1];
  logic                   sn_ready [N+1];
  sin_lane_t [NUM_CH-1:0] sn_lane  [N+1];
  logic                   sn_white [N+1];

  // Fold an angle into [-1/4, +1/4] turn with the same sine
  function automatic sin_ang_t fold_angle(angle_t a);
    sin_ang_t s;
    s = sin_ang_t'({a[15], a});
    if (s > QUARTER_TURN_S) begin
      return HALF_TURN_S - s;
    end else if (s < -QUARTER_TURN_S) begin
      return -HALF_TURN_S - s;
    end
    return s;
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sn_lane[0][k].x = CORDIC_GAIN_Q16;
      sn_lane[0][k].y = '0;
      sn_lane[0][k].s = fold_angle(a_ang_q + CH_OFFSET[k]);
    end
  end

  assign sn_valid[0] = a_valid_q;
  assign a_ready     = sn_ready[0];
  assign sn_white[0] = a_white_q;

  for (genvar i = 0; i < N; i++) begin : g_sin
    rhw_sin_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (sn_valid[i]),
      .up_ready_o (sn_ready[i]),
      .lane_i     (sn_lane[i]),
      .white_i    (sn_white[i]),
      .dn_valid_o (sn_valid[i+1]),
      .dn_ready_i (sn_ready[i+1]),
      .lane_o     (sn_lane[i+1]),
      .white_o    (sn_white[i+1])
    );
  end

  // ------------------------------------------------------- output register
  // Channel = clamp((65536 + sin) >> 9, 0, 255)
  function automatic logic [7:0] channel_of(sin_xy_t y);
    logic signed [SIN_W:0] v;
    v = {y[SIN_W-1], y} + {{(SIN_W-16){1'b0}}, 17'h10000};
    if (v[SIN_W]) begin
      return 8'd0;
    end else if (|v[SIN_W-1:17]) begin
      return 8'd255;
    end
    return v[16:9];
  endfunction

  logic       o_valid_q;
  logic [7:0] o_red_q, o_green_q, o_blue_q;

  assign sn_ready[N] = !o_valid_q || rgb_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (sn_ready[N]) begin
      o_valid_q <= sn_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sn_valid[N] && sn_ready[N]) begin
      if (sn_white[N]) begin
        o_red_q   <= 8'd255;
        o_green_q <= 8'd255;
        o_blue_q  <= 8'd255;
      end else begin
        o_red_q   <= channel_of(sn_lane[N][0].y);
        o_green_q <= channel_of(sn_lane[N][1].y);
        o_blue_q  <= channel_of(sn_lane[N][2].y);
      end
    end
  end

  assign rgb_o.valid = o_valid_q;
  assign rgb_o.red   = o_red_q;
  assign rgb_o.green = o_green_q;
  assign rgb_o.blue  = o_blue_q;

  // ------------------------------------------------------------ assertions
  `RHW_ASSERT_NXT(a_phase_adv, clk_i, rst_ni, pix_acc && pix_i.frame_start, wheel_phase_q == angle_t'($past(wheel_phase_q) + $past(phase_step_q)), "phase did not advance by the step")
  `RHW_ASSERT_NXT(a_phase_hold, clk_i, rst_ni, !(pix_acc && pix_i.frame_start), $stable(wheel_phase_q), "phase moved without a frame start")
  `RHW_ASSERT_NXT(a_accept_lands, clk_i, rst_ni, pix_acc, f_valid_q, "accepted pixel missing from first stage")
  `RHW_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !f_valid_q, pix_i.ready, "input stalled with an empty first stage")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the rotating hue wheel pattern generator.
// Depends on rhw_pkg, rhw_pixel_if, rhw_color_if and rotating_hue_wheel_pattern;
// colors are predicted with bit-exact integer CORDIC arithmetic in this file.
`default_nettype none

module tb;
  import rhw_pkg::*;

  localparam int SIDE         = 256;
  localparam int GAIN_Q16     = 39797;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int ATAN_TAB [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1, 1};
  localparam logic [15:0] THIRD_TURN     = 16'd21845;
  localparam logic [15:0] TWO_THIRD_TURN = 16'd43691;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One directed pixel; a fixed color applies where the answer is obvious
  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       fs;
    logic       fixed;
    rgb_t       color;
  } probe_t;

  localparam rgb_t WHITE = '{8'd255, 8'd255, 8'd255};
  localparam rgb_t NONE  = '{8'd0, 8'd0, 8'd0};
  localparam int NPROBE = 22;

  // Directed pixels, default registers: corners, disc edge on each axis,
  // the four pixels around the center, every quadrant, frame starts
  localparam probe_t PROBES [NPROBE] = '{
    '{8'd0,   8'd0,   1'b0, 1'b1, WHITE},
    '{8'd255, 8'd255, 1'b0, 1'b1, WHITE},
    '{8'd0,   8'd255, 1'b1, 1'b1, WHITE},
    '{8'd255, 8'd0,   1'b0, 1'b1, WHITE},
    '{8'd127, 8'd127, 1'b0, 1'b0, NONE},
    '{8'd127, 8'd128, 1'b0, 1'b0, NONE},
    '{8'd128, 8'd127, 1'b0, 1'b0, NONE},
    '{8'd128, 8'd128, 1'b0, 1'b0, NONE},
    '{8'd128, 8'd227, 1'b0, 1'b0, NONE},
    '{8'd128, 8'd228, 1'b0, 1'b1, WHITE},
    '{8'd28,  8'd128, 1'b0, 1'b0, NONE},
    '{8'd27,  8'd128, 1'b0, 1'b1, WHITE},
    '{8'd228, 8'd128, 1'b0, 1'b1, WHITE},
    '{8'd128, 8'd28,  1'b0, 1'b0, NONE},
    '{8'd180, 8'd180, 1'b0, 1'b0, NONE},
    '{8'd76,  8'd76,  1'b0, 1'b0, NONE},
    '{8'd128, 8'd200, 1'b1, 1'b0, NONE},
    '{8'd128, 8'd200, 1'b1, 1'b0, NONE},
    '{8'd127, 8'd127, 1'b1, 1'b0, NONE},
    '{8'd76,  8'd180, 1'b0, 1'b0, NONE},
    '{8'd180, 8'd76,  1'b0, 1'b0, NONE},
    '{8'd128, 8'd228, 1'b1, 1'b1, WHITE}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  rhw_pixel_if pix ();
  rhw_color_if rgb ();

  rotating_hue_wheel_pattern dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .rgb_o      (rgb),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state and the colors still owed by the block
  logic [15:0] hue_phase;
  logic [15:0] radius_reg;
  logic [15:0] step_reg;
  rgb_t        pending_colors[$];
  int unsigned error_cnt = 0;
  bit          idle_on = 1'b1;
  bit          rx_hold = 1'b0;

  // Vectoring CORDIC: angle of (x, y) as a 16-bit fraction of a turn
  function automatic logic [15:0] turn_angle(int y, int x);
    int z, dx, dy;
    if (x == 0 && y == 0) return 16'd0;
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < 15; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end
    end
    return z[15:0];
  endfunction

  // Rotation CORDIC sine, Q16, angle folded into +-quarter turn
  function automatic int sine_q16(logic [15:0] a);
    int s, x, y, dx, dy;
    s = int'(a);
    if (s >= 32768) s = s - 65536;
    if (s > 16384) s = 32768 - s;
    else if (s < -16384) s = -32768 - s;
    x = GAIN_Q16;
    y = 0;
    for (int i = 0; i < 15; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (s >= 0) begin
        x = x - dx;
        y = y + dy;
        s = s - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        s = s + ATAN_TAB[i];
      end
    end
    return y;
  endfunction

  function automatic logic [7:0] channel_level(logic [15:0] a);
    int v;
    v = 65536 + sine_q16(a);
    if (v < 0) return 8'd0;
    v = v >>> 9;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Color of one pixel; advances the wheel phase on a frame start
  function automatic rgb_t paint_pixel(logic [7:0] row, logic [7:0] col, logic fs);
    int y, x, dist_sq;
    logic [15:0] ang;
    rgb_t c;
    if (fs) hue_phase = hue_phase + step_reg;
    y = 2 * int'(row) - (SIDE - 1);
    x = 2 * int'(col) - (SIDE - 1);
    dist_sq = y * y + x * x;
    if (dist_sq > 4 * int'(radius_reg)) return WHITE;
    ang = turn_angle(y, x) + hue_phase;
    c.red   = channel_level(ang);
    c.green = channel_level(ang + THIRD_TURN);
    c.blue  = channel_level(ang + TWO_THIRD_TURN);
    return c;
  endfunction

  // Offer one pixel transaction; returns at the edge that accepts it
  task automatic send_pixel(logic [7:0] row, logic [7:0] col, logic fs,
                            logic fixed, rgb_t color);
    int gap;
    rgb_t want;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.row         <= row;
    pix.col         <= col;
    pix.frame_start <= fs;
    do @(posedge clk_i); while (!(pix.valid && pix.ready));
    want = paint_pixel(row, col, fs);
    pending_colors.push_back(fixed ? color : want);
  endtask

  // Stop offering, wait for every owed color, then let the pipe settle
  task automatic drain();
    pix.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called with the block idle
  task automatic program_regs(logic [15:0] rad, logic [15:0] stp);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RADIUS_SQ;
    cfg_wdata <= rad;
    @(posedge clk_i);
    cfg_idx   <= REG_PHASE_STEP;
    cfg_wdata <= stp;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    radius_reg = rad;
    step_reg   = stp;
  endtask

  // Stimulus: directed table, then random phases under several settings
  initial begin : stimulus
    logic [15:0] rad, stp;
    int unsigned count;
    logic [7:0] row, col;
    pix.valid       <= 1'b0;
    pix.row         <= 8'd0;
    pix.col         <= 8'd0;
    pix.frame_start <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_RADIUS_SQ;
    cfg_wdata       <= 16'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    radius_reg = RADIUS_SQ_RST;
    step_reg   = PHASE_STEP_RST;
    hue_phase  = 16'd0;
    @(posedge clk_i);

    for (int i = 0; i < NPROBE; i++)
      send_pixel(PROBES[i].row, PROBES[i].col, PROBES[i].fs,
                 PROBES[i].fixed, PROBES[i].color);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      idle_on = 1'b1;
      case (ph)
        0: begin rad = 16'd0;     stp = 16'd0;     count = 100; end
        1: begin rad = 16'd32768; stp = 16'hFFFF;  count = 450; end
        2: begin rad = 16'hFFFF;  stp = 16'd1;     count = 400; end
        default: begin
          rad   = 16'($urandom_range(0, 32768));
          stp   = 16'($urandom_range(0, 65535));
          count = 450;
        end
      endcase
      program_regs(rad, stp);
      // back-to-back traffic with one long output stall to fill the pipe
      if (ph == 1) begin
        idle_on = 1'b0;
        rx_hold = 1'b1;
      end
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          row = 8'($urandom_range(0, 255));
          col = 8'($urandom_range(0, 255));
        end else begin
          row = 8'($urandom_range(64, 191));
          col = 8'($urandom_range(64, 191));
        end
        send_pixel(row, col, $urandom_range(0, 15) == 0, 1'b0, NONE);
      end
      drain();
    end

    if (error_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Color sink: random ready gaps, plus one long hold-off on request
  initial begin : color_sink
    int gap;
    rgb.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (rx_hold) begin
        rx_hold = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        rgb.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rgb.ready <= 1'b1;
      do @(posedge clk_i); while (!(rgb.valid && rgb.ready));
    end
  end

  // Compare each accepted color transaction with the oldest expectation
  always @(posedge clk_i) begin : color_check
    rgb_t want;
    if (rst_ni && rgb.valid && rgb.ready) begin
      if (pending_colors.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected color %h %h %h", $time, rgb.red, rgb.green, rgb.blue);
      end else begin
        want = pending_colors.pop_front();
        if (rgb.red !== want.red) begin
          error_cnt++;
          $display("%0t: red expected %h actual %h", $time, want.red, rgb.red);
        end
        if (rgb.green !== want.green) begin
          error_cnt++;
          $display("%0t: green expected %h actual %h", $time, want.green, rgb.green);
        end
        if (rgb.blue !== want.blue) begin
          error_cnt++;
          $display("%0t: blue expected %h actual %h", $time, want.blue, rgb.blue);
        end
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #1000000;
    $display("tb failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/rhw_pkg.sv
rtl/rhw_pixel_if.sv
rtl/rhw_color_if.sv
rtl/rhw_atan_cell.sv
rtl/rhw_sin_cell.sv
rtl/rotating_hue_wheel_pattern.sv
tb/sv/tb.sv
